>>> src/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  localparam int unsigned CELL_W = 16;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned ADDR_W = 11;
  localparam int unsigned TAB_BITS = 3;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;

  localparam logic [7:0]        ATTR_BYTE  = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  typedef struct packed {
    logic              done;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] data;
  } result_t;

endpackage

`default_nettype wire

>>> src/text_console_writer_top.sv
// Text console with a COLUMNS x ROWS store of 16-bit cells (attribute high byte, glyph low
// byte) and a column/row cursor; every item returns the linear cursor position, and a read
// also returns the addressed cell. All store traffic goes through one single-port-write,
// registered-read memory, so an item lasts longer the more cells it touches: a printable
// character, backspace, newline without scroll, unused kind or out-of-range read finishes
// in the accept cycle, an in-range read finishes in ST_READ after the registered memory
// read, a tab writes blanks until the column is a multiple of 8, a scroll adds a pass
// that shifts the store up a row (one cell moved per cycle); a clear blanks every cell. After
// reset the block blanks all COLUMNS*ROWS cells (2000 at 80x25) in a clearing pass with
// in_stall_o high. The result sits in an output register; while it waits under out_stall_i
// the input is stalled, and the next item can be taken in the cycle it leaves.
`default_nettype none

module text_console_writer_top #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 kind_i,
  input  wire logic [7:0]                 char_code_i,
  input  wire logic [tcw_pkg::ADDR_W-1:0] read_address_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [tcw_pkg::POS_W-1:0]       cursor_pos_o,
  output logic [tcw_pkg::CELL_W-1:0]      read_data_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);

  logic                       seq_ready;
  logic                       accept;
  tcw_pkg::result_t           res;
  logic                       we;
  logic [AW-1:0]              waddr, raddr;
  logic [tcw_pkg::CELL_W-1:0] wdata, rdata;

  logic                       out_valid_q, out_valid_d;
  logic [tcw_pkg::POS_W-1:0]  pos_q;
  logic [tcw_pkg::CELL_W-1:0] data_q;

  assign in_stall_o = !(seq_ready && (!out_valid_q || !out_stall_i));
  assign accept     = in_valid_i && !in_stall_o;

  tcw_seq #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .char_code_i   (char_code_i),
    .read_address_i(read_address_i),
    .ready_o       (seq_ready),
    .res_o         (res),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .raddr_o       (raddr),
    .rdata_i       (rdata)
  );

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done) begin
      pos_q  <= res.pos;
      data_q <= res.data;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = pos_q;
  assign read_data_o  = data_q;

endmodule

`default_nettype wire

>>> src/tcw_ram.sv
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/tcw_seq.sv
`default_nettype none

module tcw_seq #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25,
  localparam int unsigned CELLS  = COLUMNS * ROWS,
  localparam int unsigned AW     = $clog2(CELLS)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire logic [1:0]                        kind_i,
  input  wire logic [7:0]                        char_code_i,
  input  wire logic [tcw_pkg::ADDR_W-1:0]        read_address_i,
  output logic                                   ready_o,
  output tcw_pkg::result_t                       res_o,
  output logic                                   we_o,
  output logic [AW-1:0]                          waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]             wdata_o,
  output logic [AW-1:0]                          raddr_o,
  input  wire logic [tcw_pkg::CELL_W-1:0]        rdata_i
);

  localparam int unsigned CW  = $clog2(COLUMNS);
  localparam int unsigned RW  = $clog2(ROWS);
  localparam int unsigned SW  = $clog2(CELLS + 1);
  localparam int unsigned LRB = (ROWS - 1) * COLUMNS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_TAB    = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  logic [2:0]    st_q, st_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic          rep_q, rep_d;

  logic          last_col, last_row;
  logic [AW-1:0] cur_idx, bs_idx;
  logic [CW-1:0] adv_col, bs_col;
  logic [RW-1:0] adv_row, bs_row, nl_row;
  logic          adv_scroll;
  logic [11:0]   pos_full;

  assign last_col = (col_q == CW'(COLUMNS - 1));
  assign last_row = (row_q == RW'(ROWS - 1));
  assign cur_idx  = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign bs_idx   = (cur_idx == '0) ? '0 : cur_idx - AW'(1);
  assign nl_row   = last_row ? row_q : row_q + RW'(1);

  // cursor after one glyph, with wrap and scroll detection
  always_comb begin
    adv_scroll = 1'b0;
    adv_row    = row_q;
    adv_col    = col_q + CW'(1);
    if (last_col) begin
      adv_col = '0;
      if (last_row) begin
        adv_scroll = 1'b1;
      end else begin
        adv_row = row_q + RW'(1);
      end
    end
  end

  always_comb begin
    bs_col = col_q;
    bs_row = row_q;
    if (col_q != '0) begin
      bs_col = col_q - CW'(1);
    end else if (row_q != '0) begin
      bs_row = row_q - RW'(1);
      bs_col = CW'(COLUMNS - 1);
    end
  end

  always_comb begin
    st_d      = st_q;
    col_d     = col_q;
    row_d     = row_q;
    cnt_d     = cnt_q;
    rep_d     = rep_q;
    we_o      = 1'b0;
    waddr_o   = cur_idx;
    wdata_o   = tcw_pkg::BLANK_CELL;
    raddr_o   = AW'(read_address_i);
    res_o.done = 1'b0;
    res_o.data = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (accept_i) begin
          unique case (kind_i)
            tcw_pkg::KIND_PUT: begin
              priority if (char_code_i == tcw_pkg::CH_NEWLINE) begin
                col_d = '0;
                row_d = nl_row;
                if (last_row) begin
                  st_d  = ST_SCROLL;
                  cnt_d = '0;
                end else begin
                  res_o.done = 1'b1;
                end
              end else if (char_code_i == tcw_pkg::CH_TAB) begin
                st_d = ST_TAB;
              end else if (char_code_i == tcw_pkg::CH_BACKSPACE) begin
                we_o       = 1'b1;
                waddr_o    = bs_idx;
                col_d      = bs_col;
                row_d      = bs_row;
                res_o.done = 1'b1;
              end else begin
                we_o    = 1'b1;
                wdata_o = {tcw_pkg::ATTR_BYTE, char_code_i};
                col_d   = adv_col;
                row_d   = adv_row;
                if (adv_scroll) begin
                  st_d  = ST_SCROLL;
                  cnt_d = '0;
                end else begin
                  res_o.done = 1'b1;
                end
              end
            end
            tcw_pkg::KIND_CLEAR: begin
              st_d  = ST_CLEAR;
              cnt_d = '0;
              col_d = '0;
              row_d = '0;
              rep_d = 1'b1;
            end
            tcw_pkg::KIND_READ: begin
              if ({2'b00, read_address_i} < 13'(CELLS)) begin
                st_d = ST_READ;
              end else begin
                res_o.done = 1'b1;
              end
            end
            default: begin
              res_o.done = 1'b1;
            end
          endcase
        end
      end
      ST_TAB: begin
        we_o  = 1'b1;
        col_d = adv_col;
        row_d = adv_row;
        if (adv_scroll) begin
          st_d  = ST_SCROLL;
          cnt_d = '0;
        end else if (adv_col[tcw_pkg::TAB_BITS-1:0] == '0) begin
          st_d       = ST_IDLE;
          res_o.done = 1'b1;
        end
      end
      ST_SCROLL: begin
        raddr_o = AW'(cnt_q + SW'(COLUMNS));
        if (cnt_q != '0) begin
          we_o    = 1'b1;
          waddr_o = AW'(cnt_q - SW'(1));
          wdata_o = (cnt_q <= SW'(LRB)) ? rdata_i : tcw_pkg::BLANK_CELL;
        end
        if (cnt_q == SW'(CELLS)) begin
          st_d       = ST_IDLE;
          res_o.done = 1'b1;
        end else begin
          cnt_d = cnt_q + SW'(1);
        end
      end
      ST_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = AW'(cnt_q);
        if (cnt_q == SW'(CELLS - 1)) begin
          st_d       = ST_IDLE;
          res_o.done = rep_q;
        end else begin
          cnt_d = cnt_q + SW'(1);
        end
      end
      ST_READ: begin
        st_d       = ST_IDLE;
        res_o.done = 1'b1;
        res_o.data = rdata_i;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
    pos_full  = 12'(row_d) * 12'(COLUMNS) + 12'(col_d);
    res_o.pos = pos_full[tcw_pkg::POS_W-1:0];
  end

  assign ready_o   = (st_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_CLEAR;
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
      rep_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
      rep_q <= rep_d;
    end
  end

endmodule

`default_nettype wire

>>> src/tcw_checker.sv
`default_nettype none

module tcw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [tcw_pkg::POS_W-1:0]  cursor_pos_o,
  input wire logic [tcw_pkg::CELL_W-1:0] read_data_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;

  // held item stays put while the sink stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cursor_pos_o) && $stable(read_data_o))
    else $error("result changed while stalled");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (12'(cursor_pos_o) < 12'(CELLS)) || (CELLS > 2048))
    else $error("cursor outside the screen");

  // every stored cell carries the fixed attribute
  a_cell_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_data_o[15:8] == tcw_pkg::ATTR_BYTE) || (read_data_o == '0))
    else $error("read data with a bad attribute");

endmodule

bind text_console_writer_top tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .cursor_pos_o(cursor_pos_o),
  .read_data_o (read_data_o)
);

`default_nettype wire
